// File: hdl/fir8_pkg.sv
// ----------------------------------------------------------------------------
// fir8_pkg
// Shared widths, types and state codes for the 8-tap digit-serial FIR filter.
// ----------------------------------------------------------------------------
package fir8_pkg;

  // sample and coefficient width, Q16.0 and Q1.15
  localparam int DATA_W    = 16;
  // digit width of the serial multiplier
  localparam int DIG_W     = 4;
  localparam int NUM_DIG   = DATA_W / DIG_W;
  localparam int DIG_CNT_W = $clog2(NUM_DIG);
  // coefficient registers and taps
  localparam int NUM_COEF  = 8;
  localparam int TAP_CNT_W = $clog2(NUM_COEF);
  localparam int DLY_DEPTH = NUM_COEF - 1;
  // sum of eight full-scale products fits in 35 bits, keep one spare
  localparam int ACC_W     = 36;
  // product of a coefficient and one signed digit
  localparam int PP_W      = DATA_W + DIG_W + 1;
  // rounding constant and result shift of the Q.15 accumulator
  localparam int FRAC_W    = 15;
  localparam int Y_W       = ACC_W - FRAC_W;
  // apb address and data
  localparam int ADDR_W    = TAP_CNT_W + 2;
  localparam int PDATA_W   = 32;

  typedef logic [NUM_COEF-1:0][DATA_W-1:0]  coef_vec_t;
  typedef logic [DLY_DEPTH-1:0][DATA_W-1:0] dly_vec_t;

  // sequencer control toward the multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic load;
    logic step;
  } mac_ctrl_t;

  // status back from the multiply-accumulate unit
  typedef struct packed {
    logic last_digit;
  } mac_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_DONE
  } fir8_state_t;

endpackage

// File: hdl/fir8_cfg.sv
// ----------------------------------------------------------------------------
// fir8_cfg
// APB register file holding the eight Q1.15 tap coefficients.
// ----------------------------------------------------------------------------
module fir8_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fir8_pkg::ADDR_W-1:0]    paddr,
  input  logic [fir8_pkg::PDATA_W-1:0]   pwdata,
  output logic [fir8_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output fir8_pkg::coef_vec_t            coefs
);
  import fir8_pkg::*;

  logic [TAP_CNT_W-1:0] reg_idx;
  logic                 wr_en;
  logic [DATA_W-1:0]    rd_coef;

  // word address selects the coefficient
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else if (wr_en) begin
      coefs[reg_idx] <= pwdata[DATA_W-1:0];
    end
  end

  // read back sign extended
  assign rd_coef = coefs[reg_idx];
  assign prdata  = {{(PDATA_W-DATA_W){rd_coef[DATA_W-1]}}, rd_coef};

endmodule

// File: hdl/fir8_mac.sv
// ----------------------------------------------------------------------------
// fir8_mac
// Digit-serial multiply-accumulate: while step is high, the tap sample shifts out
// one 4-bit digit per cycle, each digit times the coefficient is added at its weight.
// ----------------------------------------------------------------------------
module fir8_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  fir8_pkg::mac_ctrl_t               ctrl,
  input  logic signed [fir8_pkg::DATA_W-1:0] sample,
  input  logic signed [fir8_pkg::DATA_W-1:0] coef,
  output fir8_pkg::mac_stat_t               stat,
  output logic signed [fir8_pkg::ACC_W-1:0] acc
);
  import fir8_pkg::*;

  logic [DATA_W-1:0]        xsr;
  logic signed [DATA_W-1:0] cf;
  logic [DIG_CNT_W-1:0]     dig;
  logic                     last_dig;
  logic signed [DIG_W:0]    digit;
  logic signed [PP_W-1:0]   pp;
  logic signed [ACC_W-1:0]  pp_ext;
  logic signed [ACC_W-1:0]  pp_sh;

  assign last_dig        = (dig == DIG_CNT_W'(NUM_DIG - 1));
  assign stat.last_digit = last_dig;

  // top digit carries the sign, lower digits are unsigned
  assign digit  = last_dig ? {xsr[DIG_W-1], xsr[DIG_W-1:0]} : {1'b0, xsr[DIG_W-1:0]};
  assign pp     = cf * digit;
  assign pp_ext = ACC_W'(pp);
  assign pp_sh  = pp_ext <<< ({2'b00, dig} * DIG_W);

  // digit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      dig <= '0;
    end else if (ctrl.load) begin
      dig <= '0;
    end else if (ctrl.step) begin
      dig <= dig + 1'b1;
    end
  end

  // sample shift register, coefficient latch and accumulator
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      xsr <= sample;
      cf  <= coef;
      if (ctrl.clr) begin
        acc <= '0;
      end
    end else if (ctrl.step) begin
      xsr <= xsr >> DIG_W;
      acc <= acc + pp_sh;
    end
  end

endmodule

// File: hdl/fir_filter_8tap_unit.sv
// ----------------------------------------------------------------------------
// fir_filter_8tap_unit
// Direct-form FIR filter, eight taps, Q1.15 coefficients, rounded and
// saturated 16-bit output.
// ----------------------------------------------------------------------------
// Each tap is processed by a load state followed by the digit steps of the
// shared digit-serial multiply-accumulate; samples are accepted only in the
// idle state, so a new sample is not taken until the previous sum is complete.
// A new sample is taken while the previous result waits at the output.
// Reset clears coefficients, delay line and handshake state; no clear pass.
// ----------------------------------------------------------------------------
module fir_filter_8tap_unit #(
  parameter int TAPS = fir8_pkg::NUM_COEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fir8_pkg::ADDR_W-1:0]       paddr,
  input  logic [fir8_pkg::PDATA_W-1:0]      pwdata,
  output logic [fir8_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  // input stream
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [fir8_pkg::DATA_W-1:0] sample,
  // output stream
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fir8_pkg::DATA_W-1:0] filtered,
  output logic                              saturated
);
  import fir8_pkg::*;

  fir8_state_t              state;
  fir8_state_t              state_next;
  coef_vec_t                coefs;
  mac_ctrl_t                mac_ctrl;
  mac_stat_t                mac_stat;
  logic signed [ACC_W-1:0]  acc;
  logic [TAP_CNT_W-1:0]     tap_cnt;
  logic                     last_tap;
  logic [DATA_W-1:0]        x0;
  dly_vec_t                 dly;
  logic [DATA_W-1:0]        tap_sample;
  logic                     in_beat;
  logic                     out_load;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [Y_W-1:0]    y;
  logic                     y_ovf;
  logic [DATA_W-1:0]        y_sat;

  fir8_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  fir8_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (tap_sample),
    .coef   (coefs[tap_cnt]),
    .stat   (mac_stat),
    .acc    (acc)
  );

  assign last_tap = (tap_cnt == TAP_CNT_W'(TAPS - 1));
  assign in_beat  = in_valid & in_ready;

  // tap 0 is the newest sample, tap k is the sample k steps old
  assign tap_sample = (tap_cnt == '0) ? x0 : dly[tap_cnt - 1'b1];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (mac_stat.last_digit) state_next = last_tap ? ST_DONE : ST_LOAD;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    mac_ctrl      = '0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOAD: begin
        mac_ctrl.load = 1'b1;
        mac_ctrl.clr  = (tap_cnt == '0);
      end
      ST_RUN: begin
        mac_ctrl.step = 1'b1;
      end
      ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // state and tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      tap_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RUN && mac_stat.last_digit) begin
        tap_cnt <= last_tap ? '0 : tap_cnt + 1'b1;
      end
    end
  end

  // newest sample latch
  always_ff @(posedge clk) begin
    if (in_beat) begin
      x0 <= sample;
    end
  end

  // delay line shifts once the sum is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      dly <= '0;
    end else if (out_load) begin
      dly <= {dly[DLY_DEPTH-2:0], x0};
    end
  end

  // round half up, drop fraction, clip to 16 bits
  assign acc_rnd = acc + (ACC_W'(1) <<< (FRAC_W - 1));
  assign y       = acc_rnd[ACC_W-1:FRAC_W];
  assign y_ovf   = !((&y[Y_W-1:DATA_W-1]) || !(|y[Y_W-1:DATA_W-1]));
  assign y_sat   = y[Y_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered  <= y_ovf ? y_sat : y[DATA_W-1:0];
      saturated <= y_ovf;
    end
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 8-tap FIR filter: programs the Q1.15 weights
// over the register port, streams signed samples with random idle cycles
// on both sides, and compares every output beat against an in-bench
// fixed-point filter with its own weights and delay line.
// ----------------------------------------------------------------------------
module tb;
  import fir8_pkg::*;

  localparam int TAPS_USED    = NUM_COEF;
  localparam int COEF_STRIDE  = 4;
  localparam int RESET_CYCLES = 8;
  localparam int LATENCY      = 5 * TAPS_USED + 2;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RX_HOLD      = 300;
  localparam int IDLE_PCT     = 38;
  localparam int MAX_GAP      = 40;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_ITEMS  = 190;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t S_MAX = 16'sh7fff;
  localparam word_t S_MIN = 16'sh8000;
  localparam word_t HALF  = 16'sh4000;

  typedef struct {
    word_t filtered;
    logic  saturated;
  } fir_out_t;

  typedef enum int {
    MIX_FULL,
    MIX_SMALL,
    MIX_CORNER
  } sample_mix_t;

  typedef enum int {
    COEF_RANDOM,
    COEF_SMALL,
    COEF_ONE_TAP,
    COEF_CORNER,
    COEF_UNITY
  } coef_style_t;

  // fixed-point filter model plus queue of outputs still owed by the block
  class fir_scoreboard;
    int       taps;
    word_t    coef [NUM_COEF];
    word_t    history [DLY_DEPTH];
    fir_out_t filtered_q [$];
    int       errors;
    int       checked;
    int       clipped;

    function new(int n_taps);
      taps = n_taps;
      foreach (coef[i]) coef[i] = '0;
      foreach (history[i]) history[i] = '0;
      errors  = 0;
      checked = 0;
      clipped = 0;
    endfunction

    function void set_coef(int idx, word_t value);
      if (idx >= 0 && idx < NUM_COEF) coef[idx] = value;
    endfunction

    // filter one accepted sample and queue the output it must produce
    function void note_sample(word_t x);
      longint   acc;
      longint   y;
      fir_out_t r;
      int       k;
      acc = 0;
      for (k = 0; k < taps && k < NUM_COEF; k++) begin
        acc += longint'(coef[k]) * longint'((k == 0) ? x : history[k-1]);
      end
      // round half up in Q.15, then floor shift
      y = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      r.saturated = 1'b0;
      if (y > 32767) begin
        y = 32767;
        r.saturated = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        r.saturated = 1'b1;
      end
      r.filtered = word_t'(y);
      for (k = DLY_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = x;
      if (r.saturated) clipped++;
      filtered_q = {filtered_q, r};
    endfunction

    function void check_result(word_t f, logic s);
      fir_out_t e;
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing pending: filtered=%0d saturated=%0b",
                 $time, f, s);
        return;
      end
      e = filtered_q.pop_front();
      checked++;
      if (f !== e.filtered) begin
        errors++;
        $display("%0t: filtered mismatch: expected %0d actual %0d", $time, e.filtered, f);
      end
      if (s !== e.saturated) begin
        errors++;
        $display("%0t: saturated mismatch: expected %0b actual %0b", $time, e.saturated, s);
      end
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  word_t               sample;
  logic                out_valid;
  logic                out_ready;
  word_t               filtered;
  logic                saturated;

  fir_scoreboard sb;
  word_t         coef_set [NUM_COEF];
  int            tx_idle_pct;
  int            rx_idle_pct;
  int            items_sent;
  int            settings_used;
  int            cycle_count;
  logic          hold_tog  = 1'b0;
  logic          hold_seen = 1'b0;
  int            hold_left = 0;

  fir_filter_8tap_unit #(
    .TAPS(TAPS_USED)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filtered(filtered),
    .saturated(saturated)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = RX_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // beat monitor on both streams
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_sample(sample);
      if (out_valid && out_ready) sb.check_result(filtered, saturated);
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d outputs pending", $time, cycle_count,
             sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  // program all eight weights from coef_set, junk in the upper data bits
  task automatic write_coef_set();
    int i;
    for (i = 0; i < NUM_COEF; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(i * COEF_STRIDE);
      pwdata  <= {16'($urandom()), coef_set[i]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.set_coef(i, coef_set[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  // offer one input beat after a random idle gap, return once accepted
  task automatic send_sample(word_t v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // stop offering, let every pending output drain, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic word_t corner_value();
    case ($urandom_range(4))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic word_t next_sample(sample_mix_t mix);
    case (mix)
      MIX_FULL:  return word_t'($urandom());
      MIX_SMALL: return word_t'(int'($urandom_range(512)) - 256);
      default: begin
        if ($urandom_range(99) < 30) return corner_value();
        return word_t'($urandom());
      end
    endcase
  endfunction

  task automatic pick_coefs(coef_style_t style);
    foreach (coef_set[i]) begin
      case (style)
        COEF_RANDOM: coef_set[i] = word_t'($urandom());
        COEF_SMALL:  coef_set[i] = word_t'(int'($urandom_range(4096)) - 2048);
        COEF_CORNER: coef_set[i] = corner_value();
        default:     coef_set[i] = '0;
      endcase
    end
    if (style == COEF_ONE_TAP) coef_set[$urandom_range(NUM_COEF-1)] = word_t'($urandom());
    if (style == COEF_UNITY) coef_set[0] = S_MAX;
  endtask

  task automatic run_phase(int n, sample_mix_t mix, bit with_hold, bit with_pause);
    int i;
    for (i = 0; i < n; i++) begin
      // receiver holds off while the sender keeps pushing
      if (with_hold && i == n / 3) hold_tog <= ~hold_tog;
      // sender waits for every pending output mid-phase
      if (with_pause && i == n / 2) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send_sample(next_sample(mix));
    end
  endtask

  // main sequence
  initial begin
    int p;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    sample        = '0;
    out_ready     = 1'b0;
    tx_idle_pct   = IDLE_PCT;
    rx_idle_pct   = IDLE_PCT;
    items_sent    = 0;
    settings_used = 0;
    sb = new(TAPS_USED);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset weights are zero, output must be zero
    send_sample(S_MAX);
    send_sample(S_MIN);
    wait_idle();

    // positive full-scale weights: clip high, then negative samples enter the taps
    foreach (coef_set[i]) coef_set[i] = S_MAX;
    write_coef_set();
    repeat (8) send_sample(S_MAX);
    repeat (4) send_sample(S_MIN);
    wait_idle();

    // half weight on the newest tap only: ties round up
    foreach (coef_set[i]) coef_set[i] = '0;
    coef_set[0] = HALF;
    write_coef_set();
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd3);
    send_sample(-16'sd3);
    wait_idle();

    // negative full-scale weights against negative full-scale samples
    foreach (coef_set[i]) coef_set[i] = S_MIN;
    write_coef_set();
    repeat (7) send_sample(S_MIN);
    wait_idle();

    // random phases, each with a fresh weight set
    for (p = 0; p < RAND_PHASES; p++) begin
      pick_coefs(coef_style_t'(p % 5));
      write_coef_set();
      tx_idle_pct = (p == 2) ? 0 : IDLE_PCT;
      rx_idle_pct = (p == 2) ? 0 : IDLE_PCT;
      run_phase(PHASE_ITEMS, sample_mix_t'(p % 3), p == 4, p == 6);
      wait_idle();
    end

    $display("run covered %0d samples over %0d weight settings", items_sent, settings_used);
    $display("%0d outputs checked, %0d clipped to full scale", sb.checked, sb.clipped);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
